### rtl/ndl_pkg.sv
// ============================================================================
// ndl_pkg - shared types and constants of the nested delimiter lexer
// Context codes, result kinds, error codes, the character codes that the
// classifier recognises and the control word passed to the context stack.
// ============================================================================
package ndl_pkg;

    // Context held in one stack entry.
    typedef enum logic [2:0] {
        CTX_NONE,
        CTX_DQUOTE,
        CTX_SQUOTE,
        CTX_ARRAY,
        CTX_PAREN,
        CTX_BRACE
    } ctx_t;

    localparam int KIND_W     = 5;
    localparam int ERR_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int POS_FIELD_W = 16;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_TEXT         = 5'd0;
    localparam logic [KIND_W-1:0] KIND_DQUOTE_OPEN  = 5'd1;
    localparam logic [KIND_W-1:0] KIND_DQUOTE_CLOSE = 5'd2;
    localparam logic [KIND_W-1:0] KIND_SQUOTE_OPEN  = 5'd3;
    localparam logic [KIND_W-1:0] KIND_SQUOTE_CLOSE = 5'd4;
    localparam logic [KIND_W-1:0] KIND_SPACE        = 5'd5;
    localparam logic [KIND_W-1:0] KIND_ARRAY_OPEN   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_ARRAY_CLOSE  = 5'd7;
    localparam logic [KIND_W-1:0] KIND_COMMA        = 5'd8;
    localparam logic [KIND_W-1:0] KIND_PAREN_OPEN   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_PAREN_CLOSE  = 5'd10;
    localparam logic [KIND_W-1:0] KIND_BRACE_OPEN   = 5'd11;
    localparam logic [KIND_W-1:0] KIND_BRACE_CLOSE  = 5'd12;
    localparam logic [KIND_W-1:0] KIND_DIGIT        = 5'd13;
    localparam logic [KIND_W-1:0] KIND_DASH         = 5'd14;
    localparam logic [KIND_W-1:0] KIND_END_OK       = 5'd15;
    localparam logic [KIND_W-1:0] KIND_ERROR        = 5'd16;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SPACE       = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_BRACKET = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_COMMA   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_PAREN   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_BAD_BRACE   = 3'd5;
    localparam logic [ERR_W-1:0] ERR_UNTERM      = 3'd6;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW    = 3'd7;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_DQUOTE   = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE   = 8'h27;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_COMMA    = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_LPAREN   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN   = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACE   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE   = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_DASH     = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;

    // Stack control for one transaction.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        ctx_t ctx;
    } stk_ctl_t;

endpackage

### rtl/ndl_classify.sv
// ============================================================================
// ndl_classify - character classifier
// Decides the kind, the error code and the stack operation for one item
// from the character, the top context and the sticky error.
// ============================================================================
module ndl_classify
(
    input  logic [ndl_pkg::CHAR_W-1:0] character,
    input  logic                       end_of_line,
    input  logic                       stack_empty,
    input  logic                       stack_full,
    input  ndl_pkg::ctx_t              top_ctx,
    input  logic [ndl_pkg::ERR_W-1:0]  sticky_err,
    output logic [ndl_pkg::KIND_W-1:0] kind,
    output logic [ndl_pkg::ERR_W-1:0]  err_code,
    output logic                       set_err,
    output logic                       use_top_pos,
    output ndl_pkg::stk_ctl_t          ctl
);

    ndl_pkg::ctx_t top;
    ndl_pkg::ctx_t open_ctx;
    logic          quoted;
    logic          is_open;

    assign top    = stack_empty ? ndl_pkg::CTX_NONE : top_ctx;
    assign quoted = (top == ndl_pkg::CTX_DQUOTE) || (top == ndl_pkg::CTX_SQUOTE);

    always_comb
    begin
        kind        = ndl_pkg::KIND_TEXT;
        err_code    = ndl_pkg::ERR_NONE;
        set_err     = 1'b0;
        use_top_pos = 1'b0;
        ctl         = '{push: 1'b0, pop: 1'b0, clear: 1'b0, ctx: ndl_pkg::CTX_NONE};
        open_ctx    = ndl_pkg::CTX_NONE;
        is_open     = 1'b0;

        if (end_of_line)
        begin
            ctl.clear = 1'b1;
            if (sticky_err != ndl_pkg::ERR_NONE)
            begin
                kind     = ndl_pkg::KIND_ERROR;
                err_code = sticky_err;
            end
            else if (!stack_empty)
            begin
                kind        = ndl_pkg::KIND_ERROR;
                err_code    = ndl_pkg::ERR_UNTERM;
                use_top_pos = 1'b1;
            end
            else
            begin
                kind = ndl_pkg::KIND_END_OK;
            end
        end
        else if (sticky_err != ndl_pkg::ERR_NONE)
        begin
            kind     = ndl_pkg::KIND_ERROR;
            err_code = sticky_err;
        end
        else
        begin
            case (character)
                ndl_pkg::CH_DQUOTE:
                begin
                    if (top == ndl_pkg::CTX_DQUOTE)
                    begin
                        ctl.pop = 1'b1;
                        kind    = ndl_pkg::KIND_DQUOTE_CLOSE;
                    end
                    else if (!quoted)
                    begin
                        is_open  = 1'b1;
                        open_ctx = ndl_pkg::CTX_DQUOTE;
                        kind     = ndl_pkg::KIND_DQUOTE_OPEN;
                    end
                end
                ndl_pkg::CH_SQUOTE:
                begin
                    if (top == ndl_pkg::CTX_SQUOTE)
                    begin
                        ctl.pop = 1'b1;
                        kind    = ndl_pkg::KIND_SQUOTE_CLOSE;
                    end
                    else if (!quoted)
                    begin
                        is_open  = 1'b1;
                        open_ctx = ndl_pkg::CTX_SQUOTE;
                        kind     = ndl_pkg::KIND_SQUOTE_OPEN;
                    end
                end
                ndl_pkg::CH_SPACE:
                begin
                    if (top == ndl_pkg::CTX_BRACE)
                        err_code = ndl_pkg::ERR_SPACE;
                    else if (!quoted)
                        kind = ndl_pkg::KIND_SPACE;
                end
                ndl_pkg::CH_LBRACKET:
                begin
                    if (!quoted)
                    begin
                        is_open  = 1'b1;
                        open_ctx = ndl_pkg::CTX_ARRAY;
                        kind     = ndl_pkg::KIND_ARRAY_OPEN;
                    end
                end
                ndl_pkg::CH_RBRACKET:
                begin
                    if (!quoted)
                    begin
                        if (top == ndl_pkg::CTX_ARRAY)
                        begin
                            ctl.pop = 1'b1;
                            kind    = ndl_pkg::KIND_ARRAY_CLOSE;
                        end
                        else
                            err_code = ndl_pkg::ERR_BAD_BRACKET;
                    end
                end
                ndl_pkg::CH_COMMA:
                begin
                    if (!quoted)
                    begin
                        if (top == ndl_pkg::CTX_ARRAY || top == ndl_pkg::CTX_PAREN)
                            kind = ndl_pkg::KIND_COMMA;
                        else
                            err_code = ndl_pkg::ERR_BAD_COMMA;
                    end
                end
                ndl_pkg::CH_LPAREN:
                begin
                    if (!quoted)
                    begin
                        is_open  = 1'b1;
                        open_ctx = ndl_pkg::CTX_PAREN;
                        kind     = ndl_pkg::KIND_PAREN_OPEN;
                    end
                end
                ndl_pkg::CH_RPAREN:
                begin
                    if (!quoted)
                    begin
                        if (top == ndl_pkg::CTX_PAREN)
                        begin
                            ctl.pop = 1'b1;
                            kind    = ndl_pkg::KIND_PAREN_CLOSE;
                        end
                        else
                            err_code = ndl_pkg::ERR_BAD_PAREN;
                    end
                end
                ndl_pkg::CH_LBRACE:
                begin
                    if (!quoted)
                    begin
                        is_open  = 1'b1;
                        open_ctx = ndl_pkg::CTX_BRACE;
                        kind     = ndl_pkg::KIND_BRACE_OPEN;
                    end
                end
                ndl_pkg::CH_RBRACE:
                begin
                    if (!quoted)
                    begin
                        if (top == ndl_pkg::CTX_BRACE)
                        begin
                            ctl.pop = 1'b1;
                            kind    = ndl_pkg::KIND_BRACE_CLOSE;
                        end
                        else
                            err_code = ndl_pkg::ERR_BAD_BRACE;
                    end
                end
                ndl_pkg::CH_DASH:
                begin
                    if (!quoted)
                        kind = ndl_pkg::KIND_DASH;
                end
                default:
                begin
                    if (character inside {[ndl_pkg::CH_ZERO:ndl_pkg::CH_NINE]} && !quoted)
                        kind = ndl_pkg::KIND_DIGIT;
                end
            endcase

            // An opener with the stack already full is an overflow.
            if (err_code == ndl_pkg::ERR_NONE && is_open)
            begin
                if (stack_full)
                    err_code = ndl_pkg::ERR_OVERFLOW;
                else
                begin
                    ctl.push = 1'b1;
                    ctl.ctx  = open_ctx;
                end
            end

            if (err_code != ndl_pkg::ERR_NONE)
            begin
                kind    = ndl_pkg::KIND_ERROR;
                set_err = 1'b1;
            end
        end
    end

endmodule

### rtl/ndl_stack.sv
// ============================================================================
// ndl_stack - context stack
// Holds open contexts in a memory, with the top entry kept in a register
// so that each character sees it without a read delay.
// ============================================================================
module ndl_stack
#(
    parameter int STACK_DEPTH   = 16,
    parameter int POSITION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  ndl_pkg::stk_ctl_t        ctl,
    input  logic [POSITION_BITS-1:0] push_pos,
    output logic                     stack_empty,
    output logic                     stack_full,
    output ndl_pkg::ctx_t            top_ctx,
    output logic [POSITION_BITS-1:0] top_pos
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    typedef struct packed {
        ndl_pkg::ctx_t            ctx;
        logic [POSITION_BITS-1:0] pos;
    } entry_t;

    entry_t           stack_mem [STACK_DEPTH];
    entry_t           top_reg;
    entry_t           new_entry;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] below_top;

    assign new_entry   = '{ctx: ctl.ctx, pos: push_pos};
    assign wr_addr     = count_reg[IDX_W-1:0];
    assign below_top   = count_reg - CNT_W'(2);
    assign rd_addr     = below_top[IDX_W-1:0];
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign top_ctx     = top_reg.ctx;
    assign top_pos     = top_reg.pos;

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
            count_next = '0;
        else if (ctl.push)
            count_next = count_reg + CNT_W'(1);
        else if (ctl.pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (advance)
            count_reg <= count_next;
    end

    // On a pop the entry below the old top becomes the new top.
    always_ff @(posedge clk)
    begin
        if (advance && ctl.push)
        begin
            stack_mem[wr_addr] <= new_entry;
            top_reg            <= new_entry;
        end
        else if (advance && ctl.pop)
        begin
            top_reg <= stack_mem[rd_addr];
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("context stack count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ctl.push |-> !stack_full)
        else $error("push into a full context stack");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ctl.pop |-> !stack_empty)
        else $error("pop from an empty context stack");
`endif

endmodule

### rtl/nested_delimiter_lexer_core.sv
// ============================================================================
// nested_delimiter_lexer_core - command line lexer with nested contexts
// Classifies one character per transaction, tracking quotes, arrays, parens
// and braces on a bounded stack, with sticky errors until end of line.
//
//  Channel | Signals                         | Contents
//  --------+---------------------------------+----------------------------------
//  input   | s_tvalid s_tready s_tdata s_tlast| character, end of line on tlast
//  output  | m_tvalid m_tready m_tdata m_tuser| echo, position, error; kind
//
// One character is accepted per cycle while the output is not stalled; each
// gives exactly one result, held in the result register (the input register
// loads at acceptance, the result register when the item advances). The
// rate is set by the single classify step, which only looks at the stack top
// register.
// Reset clears the stack count, the position counter, the sticky error and
// both valid flags; no clearing pass is needed. A stalled output holds the
// result and stops the input register from advancing.
// ============================================================================
module nested_delimiter_lexer_core
#(
    parameter int STACK_DEPTH   = 16,
    parameter int POSITION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] echo_char, [23:8] position,
                                   // [26:24] error_code, [31:27] zero
    output logic [4:0]  m_tuser    // [4:0] kind
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Input register stage.
    logic                              in_valid_reg;
    logic [ndl_pkg::CHAR_W-1:0]        in_char_reg;
    logic                              in_eol_reg;

    // Line state.
    logic [POSITION_BITS-1:0]          cpos_reg;
    logic [POSITION_BITS-1:0]          cpos_next;
    logic [ndl_pkg::ERR_W-1:0]         sticky_reg;
    logic [ndl_pkg::ERR_W-1:0]         sticky_next;

    // Result register stage.
    logic                              out_valid_reg;
    logic [ndl_pkg::KIND_W-1:0]        out_kind_reg;
    logic [ndl_pkg::CHAR_W-1:0]        out_char_reg;
    logic [ndl_pkg::POS_FIELD_W-1:0]   out_pos_reg;
    logic [ndl_pkg::ERR_W-1:0]         out_err_reg;

    // Classifier and stack.
    logic                              advance;
    logic                              stack_empty;
    logic                              stack_full;
    ndl_pkg::ctx_t                     top_ctx;
    logic [POSITION_BITS-1:0]          top_pos;
    logic [ndl_pkg::KIND_W-1:0]        kind;
    logic [ndl_pkg::ERR_W-1:0]         err_code;
    logic                              set_err;
    logic                              use_top_pos;
    ndl_pkg::stk_ctl_t                 ctl;
    logic [POSITION_BITS-1:0]          res_pos_full;
    logic [ndl_pkg::POS_FIELD_W-1:0]   res_pos;

    // The item in the input register moves on whenever the result register
    // is free or is being emptied in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ndl_classify u_classify
    (
        .character   (in_char_reg),
        .end_of_line (in_eol_reg),
        .stack_empty (stack_empty),
        .stack_full  (stack_full),
        .top_ctx     (top_ctx),
        .sticky_err  (sticky_reg),
        .kind        (kind),
        .err_code    (err_code),
        .set_err     (set_err),
        .use_top_pos (use_top_pos),
        .ctl         (ctl)
    );

    ndl_stack
    #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    )
    u_stack
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .ctl         (ctl),
        .push_pos    (cpos_reg),
        .stack_empty (stack_empty),
        .stack_full  (stack_full),
        .top_ctx     (top_ctx),
        .top_pos     (top_pos)
    );

    // An unterminated context reports where its opener stood; everything
    // else reports the current position (the line length at end of line).
    assign res_pos_full = use_top_pos ? top_pos : cpos_reg;

    generate
        if (POSITION_BITS >= ndl_pkg::POS_FIELD_W)
        begin : g_pos_trim
            assign res_pos = res_pos_full[ndl_pkg::POS_FIELD_W-1:0];
        end
        else
        begin : g_pos_ext
            assign res_pos = {{(ndl_pkg::POS_FIELD_W - POSITION_BITS){1'b0}}, res_pos_full};
        end
    endgenerate

    // The position saturates at its top value; end of line starts a new line.
    always_comb
    begin
        cpos_next   = cpos_reg;
        sticky_next = sticky_reg;
        if (in_eol_reg)
        begin
            cpos_next   = '0;
            sticky_next = ndl_pkg::ERR_NONE;
        end
        else
        begin
            if (cpos_reg != POS_MAX)
                cpos_next = cpos_reg + POSITION_BITS'(1);
            if (set_err)
                sticky_next = err_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cpos_reg      <= '0;
            sticky_reg    <= ndl_pkg::ERR_NONE;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cpos_reg      <= cpos_next;
                sticky_reg    <= sticky_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
        if (advance)
        begin
            out_kind_reg <= kind;
            out_char_reg <= in_eol_reg ? '0 : in_char_reg;
            out_pos_reg  <= res_pos;
            out_err_reg  <= err_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b0, out_err_reg, out_pos_reg, out_char_reg};

`ifndef SYNTH
    a_err_with_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_kind_reg == ndl_pkg::KIND_ERROR)
                           == (out_err_reg != ndl_pkg::ERR_NONE)))
        else $error("error code and error kind disagree");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_eol_reg |=> (cpos_reg == '0) && (sticky_reg == ndl_pkg::ERR_NONE))
        else $error("line state not cleared at end of line");

    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (sticky_reg != ndl_pkg::ERR_NONE) && !(advance && in_eol_reg)
        |=> sticky_reg == $past(sticky_reg))
        else $error("sticky error changed within a line");
`endif

endmodule

### bench/nested_delimiter_lexer_core_test.sv
// ============================================================================
// nested_delimiter_lexer_core_test - self-checking bench for the lexer core
// Streams command lines into the lexer and checks every classified result
// against a behavioural predictor. Directed lines come first, followed by
// well-formed nested lines, deep lines that often overflow the stack and noise
// lines.
// ============================================================================
`timescale 1ns / 100ps

module nested_delimiter_lexer_core_test;

    // Depth of the context stack and the saturated position, as in the core.
    localparam int          CTX_DEPTH      = 16;
    localparam logic [15:0] POS_SATURATED  = 16'hFFFF;
    localparam int          RANDOM_ITEMS   = 1550;
    localparam int          CLOSING_ITEMS  = 200;
    // The receiver stops once, for a long stretch, after this many results.
    localparam int          HOLD_AT        = 100;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          DRAIN_LIMIT    = 2000;
    localparam int          MAX_MESSAGES   = 50;

    // One character transaction waiting to be offered to the core.
    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } char_item_t;

    // One classified token as the core should report it.
    typedef struct {
        logic [ndl_pkg::KIND_W-1:0] kind;
        logic [7:0]                 echo;
        logic [15:0]                pos;
        logic [ndl_pkg::ERR_W-1:0]  err;
    } token_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] character
    logic        s_tlast = 1'b0;      // end_of_line
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // [7:0] echo_char, [23:8] position,
                                      // [26:24] error_code, [31:27] zero
    logic [4:0]  m_tuser;             // [4:0] kind

    // Stimulus waiting to be sent, and the tokens that the core still owes us.
    char_item_t  pending_chars[$];
    token_t      expected_tokens[$];

    // Predictor state: the open contexts, the line position and the sticky error.
    ndl_pkg::ctx_t ctx_stack[CTX_DEPTH];
    logic [15:0] opener_pos[CTX_DEPTH];
    int unsigned ctx_count;
    logic [15:0] line_pos;
    logic [2:0]  line_error;

    // Idling is switched off for the closing stretch.
    logic        idle_enable = 1'b1;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          hold_left = 0;
    int          hold_count = 0;
    logic        hold_done = 1'b0;

    int          queued_items = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          lines_closed = 0;
    int          deepest = 0;
    logic [16:0] kinds_seen = '0;
    logic [7:0]  errors_seen = '0;

    nested_delimiter_lexer_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor. Works out the token for one accepted character transaction
    // and advances the context stack exactly as the lexer is meant to.
    // ------------------------------------------------------------------------
    function automatic token_t classify_char(input logic [7:0] ch, input logic eol);
        token_t                     tok;
        ndl_pkg::ctx_t              top;
        logic                       quoted;
        logic [ndl_pkg::KIND_W-1:0] kind;
        logic [ndl_pkg::ERR_W-1:0]  err;
        logic [15:0]                pos;
        ndl_pkg::ctx_t              opened;
        pos  = line_pos;
        kind = ndl_pkg::KIND_TEXT;
        err  = ndl_pkg::ERR_NONE;
        if (eol)
        begin
            // The end of a line reports the worst news and then forgets it all.
            if (line_error != ndl_pkg::ERR_NONE)
                tok = '{ndl_pkg::KIND_ERROR, 8'h00, pos, line_error};
            else if (ctx_count != 0)
                tok = '{ndl_pkg::KIND_ERROR, 8'h00, opener_pos[ctx_count - 1],
                        ndl_pkg::ERR_UNTERM};
            else
                tok = '{ndl_pkg::KIND_END_OK, 8'h00, pos, ndl_pkg::ERR_NONE};
            ctx_count  = 0;
            line_pos   = '0;
            line_error = ndl_pkg::ERR_NONE;
            lines_closed++;
        end
        else
        begin
            if (line_pos != POS_SATURATED)
                line_pos = line_pos + 16'd1;
            if (line_error != ndl_pkg::ERR_NONE)
                tok = '{ndl_pkg::KIND_ERROR, ch, pos, line_error};
            else
            begin
                top    = (ctx_count != 0) ? ctx_stack[ctx_count - 1] : ndl_pkg::CTX_NONE;
                quoted = (top == ndl_pkg::CTX_DQUOTE) || (top == ndl_pkg::CTX_SQUOTE);
                case (ch)
                    ndl_pkg::CH_DQUOTE:
                        if (top == ndl_pkg::CTX_DQUOTE)
                        begin
                            ctx_count--;
                            kind = ndl_pkg::KIND_DQUOTE_CLOSE;
                        end
                        else if (!quoted)
                            kind = ndl_pkg::KIND_DQUOTE_OPEN;
                    ndl_pkg::CH_SQUOTE:
                        if (top == ndl_pkg::CTX_SQUOTE)
                        begin
                            ctx_count--;
                            kind = ndl_pkg::KIND_SQUOTE_CLOSE;
                        end
                        else if (!quoted)
                            kind = ndl_pkg::KIND_SQUOTE_OPEN;
                    ndl_pkg::CH_SPACE:
                        if (top == ndl_pkg::CTX_BRACE)
                            err = ndl_pkg::ERR_SPACE;
                        else if (!quoted)
                            kind = ndl_pkg::KIND_SPACE;
                    ndl_pkg::CH_LBRACKET:
                        if (!quoted)
                            kind = ndl_pkg::KIND_ARRAY_OPEN;
                    ndl_pkg::CH_RBRACKET:
                        if (!quoted)
                        begin
                            if (top == ndl_pkg::CTX_ARRAY)
                            begin
                                ctx_count--;
                                kind = ndl_pkg::KIND_ARRAY_CLOSE;
                            end
                            else
                                err = ndl_pkg::ERR_BAD_BRACKET;
                        end
                    ndl_pkg::CH_COMMA:
                        if (!quoted)
                        begin
                            if (top == ndl_pkg::CTX_ARRAY || top == ndl_pkg::CTX_PAREN)
                                kind = ndl_pkg::KIND_COMMA;
                            else
                                err = ndl_pkg::ERR_BAD_COMMA;
                        end
                    ndl_pkg::CH_LPAREN:
                        if (!quoted)
                            kind = ndl_pkg::KIND_PAREN_OPEN;
                    ndl_pkg::CH_RPAREN:
                        if (!quoted)
                        begin
                            if (top == ndl_pkg::CTX_PAREN)
                            begin
                                ctx_count--;
                                kind = ndl_pkg::KIND_PAREN_CLOSE;
                            end
                            else
                                err = ndl_pkg::ERR_BAD_PAREN;
                        end
                    ndl_pkg::CH_LBRACE:
                        if (!quoted)
                            kind = ndl_pkg::KIND_BRACE_OPEN;
                    ndl_pkg::CH_RBRACE:
                        if (!quoted)
                        begin
                            if (top == ndl_pkg::CTX_BRACE)
                            begin
                                ctx_count--;
                                kind = ndl_pkg::KIND_BRACE_CLOSE;
                            end
                            else
                                err = ndl_pkg::ERR_BAD_BRACE;
                        end
                    ndl_pkg::CH_DASH:
                        if (!quoted)
                            kind = ndl_pkg::KIND_DASH;
                    default:
                        if (ch >= ndl_pkg::CH_ZERO && ch <= ndl_pkg::CH_NINE && !quoted)
                            kind = ndl_pkg::KIND_DIGIT;
                endcase

                // An opener pushes a context unless the stack is already full.
                if (err == ndl_pkg::ERR_NONE && (kind == ndl_pkg::KIND_DQUOTE_OPEN ||
                    kind == ndl_pkg::KIND_SQUOTE_OPEN || kind == ndl_pkg::KIND_ARRAY_OPEN ||
                    kind == ndl_pkg::KIND_PAREN_OPEN || kind == ndl_pkg::KIND_BRACE_OPEN))
                begin
                    if (ctx_count >= CTX_DEPTH)
                        err = ndl_pkg::ERR_OVERFLOW;
                    else
                    begin
                        case (kind)
                            ndl_pkg::KIND_DQUOTE_OPEN: opened = ndl_pkg::CTX_DQUOTE;
                            ndl_pkg::KIND_SQUOTE_OPEN: opened = ndl_pkg::CTX_SQUOTE;
                            ndl_pkg::KIND_ARRAY_OPEN:  opened = ndl_pkg::CTX_ARRAY;
                            ndl_pkg::KIND_PAREN_OPEN:  opened = ndl_pkg::CTX_PAREN;
                            default:                   opened = ndl_pkg::CTX_BRACE;
                        endcase
                        ctx_stack[ctx_count]  = opened;
                        opener_pos[ctx_count] = pos;
                        ctx_count++;
                        if (ctx_count > deepest)
                            deepest = ctx_count;
                    end
                end

                if (err != ndl_pkg::ERR_NONE)
                begin
                    line_error = err;
                    tok = '{ndl_pkg::KIND_ERROR, ch, pos, err};
                end
                else
                    tok = '{kind, ch, pos, ndl_pkg::ERR_NONE};
            end
        end
        kinds_seen[tok.kind] = 1'b1;
        errors_seen[tok.err] = 1'b1;
        return tok;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] ch);
        pending_chars.push_back('{ch, 1'b0});
        queued_items++;
    endtask

    // The character lane carries junk on an end-of-line transaction; the core
    // must ignore it.
    task automatic send_eol();
        pending_chars.push_back('{8'($urandom_range(0, 255)), 1'b1});
        queued_items++;
    endtask

    function automatic logic is_special(input logic [7:0] ch);
        case (ch)
            ndl_pkg::CH_DQUOTE, ndl_pkg::CH_SQUOTE, ndl_pkg::CH_SPACE,
            ndl_pkg::CH_LBRACKET, ndl_pkg::CH_RBRACKET, ndl_pkg::CH_COMMA,
            ndl_pkg::CH_LPAREN, ndl_pkg::CH_RPAREN, ndl_pkg::CH_LBRACE,
            ndl_pkg::CH_RBRACE, ndl_pkg::CH_DASH:
                return 1'b1;
            default:
                return ch >= ndl_pkg::CH_ZERO && ch <= ndl_pkg::CH_NINE;
        endcase
    endfunction

    // A character that classifies as plain text outside any quote.
    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(1, 255));
        while (is_special(ch));
        return ch;
    endfunction

    function automatic logic [7:0] open_char(input ndl_pkg::ctx_t c);
        case (c)
            ndl_pkg::CTX_DQUOTE: return ndl_pkg::CH_DQUOTE;
            ndl_pkg::CTX_SQUOTE: return ndl_pkg::CH_SQUOTE;
            ndl_pkg::CTX_ARRAY:  return ndl_pkg::CH_LBRACKET;
            ndl_pkg::CTX_PAREN:  return ndl_pkg::CH_LPAREN;
            default:             return ndl_pkg::CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input ndl_pkg::ctx_t c);
        case (c)
            ndl_pkg::CTX_DQUOTE: return ndl_pkg::CH_DQUOTE;
            ndl_pkg::CTX_SQUOTE: return ndl_pkg::CH_SQUOTE;
            ndl_pkg::CTX_ARRAY:  return ndl_pkg::CH_RBRACKET;
            ndl_pkg::CTX_PAREN:  return ndl_pkg::CH_RPAREN;
            default:             return ndl_pkg::CH_RBRACE;
        endcase
    endfunction

    function automatic logic [7:0] open_or_close_char();
        ndl_pkg::ctx_t c;
        c = ndl_pkg::ctx_t'($urandom_range(int'(ndl_pkg::CTX_DQUOTE),
                                           int'(ndl_pkg::CTX_BRACE)));
        return $urandom_range(0, 1) ? open_char(c) : close_char(c);
    endfunction

    // A character that is legal with the given context on top of the stack.
    function automatic logic [7:0] content_for(input ndl_pkg::ctx_t top);
        logic [7:0] ch;
        int         pick;
        pick = $urandom_range(0, 99);
        if (top == ndl_pkg::CTX_DQUOTE || top == ndl_pkg::CTX_SQUOTE)
        begin
            do
                ch = 8'($urandom_range(1, 255));
            while (ch == close_char(top));
        end
        else if (pick < 15)
            ch = ndl_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        else if (pick < 25)
            ch = ndl_pkg::CH_DASH;
        else if (pick < 40 && top != ndl_pkg::CTX_BRACE)
            ch = ndl_pkg::CH_SPACE;
        else if (pick < 55 && (top == ndl_pkg::CTX_ARRAY || top == ndl_pkg::CTX_PAREN))
            ch = ndl_pkg::CH_COMMA;
        else
            ch = plain_char();
        return ch;
    endfunction

    // A well-formed line of random shape; now and then it is left unterminated.
    task automatic gen_nested_line(input int max_len);
        ndl_pkg::ctx_t opened[$];
        ndl_pkg::ctx_t top;
        ndl_pkg::ctx_t c;
        int            n;
        int            pick;
        for (n = 0; n < max_len; n++)
        begin
            top  = (opened.size() != 0) ? opened[$] : ndl_pkg::CTX_NONE;
            pick = $urandom_range(0, 99);
            if ((top == ndl_pkg::CTX_DQUOTE || top == ndl_pkg::CTX_SQUOTE) && pick < 25)
            begin
                send_char(close_char(top));
                void'(opened.pop_back());
            end
            else if (top != ndl_pkg::CTX_DQUOTE && top != ndl_pkg::CTX_SQUOTE &&
                     pick < 20 && opened.size() < 8)
            begin
                c = ndl_pkg::ctx_t'($urandom_range(int'(ndl_pkg::CTX_DQUOTE),
                                                   int'(ndl_pkg::CTX_BRACE)));
                send_char(open_char(c));
                opened.push_back(c);
            end
            else if (top != ndl_pkg::CTX_DQUOTE && top != ndl_pkg::CTX_SQUOTE &&
                     pick < 35 && opened.size() != 0)
            begin
                send_char(close_char(top));
                void'(opened.pop_back());
            end
            else
                send_char(content_for(top));
        end
        if ($urandom_range(0, 3) != 0)
            while (opened.size() != 0)
                send_char(close_char(opened.pop_back()));
        send_eol();
    endtask

    // Deep nesting that often fills the context stack and can overflow it.
    task automatic gen_deep_line();
        ndl_pkg::ctx_t opened[$];
        ndl_pkg::ctx_t c;
        int            depth;
        int            i;
        depth = $urandom_range(12, CTX_DEPTH + 3);
        for (i = 0; i < depth; i++)
        begin
            c = ndl_pkg::ctx_t'($urandom_range(int'(ndl_pkg::CTX_ARRAY),
                                               int'(ndl_pkg::CTX_BRACE)));
            send_char(open_char(c));
            opened.push_back(c);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            c = ndl_pkg::ctx_t'($urandom_range(int'(ndl_pkg::CTX_DQUOTE),
                                               int'(ndl_pkg::CTX_SQUOTE)));
            send_char(open_char(c));
            opened.push_back(c);
        end
        send_char(content_for(opened[$]));
        while (opened.size() > $urandom_range(0, 2))
            send_char(close_char(opened.pop_back()));
        send_eol();
    endtask

    // Mostly delimiters in no particular order, so that errors turn up.
    task automatic gen_noise_line();
        int len;
        int i;
        len = $urandom_range(1, 30);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) < 6)
                send_char(content_for(ndl_pkg::CTX_ARRAY) == ndl_pkg::CH_COMMA ?
                          ndl_pkg::CH_COMMA : open_or_close_char());
            else
                send_char(8'($urandom_range(1, 255)));
        end
        send_eol();
    endtask

    // Waits until everything sent has been accepted and answered. The check
    // runs on the falling edge, once the rising edge has settled.
    task automatic wait_quiet();
        while (pending_chars.size() != 0 || s_tvalid || expected_tokens.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver. Offers the pending characters, with random gaps between them,
    // and feeds every accepted transaction to the predictor.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        char_item_t item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_tokens.push_back(classify_char(s_tdata, s_tlast));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_chars.size() == 0)
                    s_tvalid <= 1'b0;
                else if (idle_enable && $urandom_range(0, 9) == 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= $urandom_range(1, 19) - 1;
                end
                else
                begin
                    item = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.ch;
                    s_tlast  <= item.eol;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold. Counts accepted results and, once enough have gone
    // by, holds the output off while hold_left counts down, so that the core
    // fills up and pushes back on its input.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                hold_count <= hold_count + 1;
            if (!hold_done && hold_count >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Checks each result transaction against the oldest expected
    // token and throttles the output with random stalls.
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_MESSAGES)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_MESSAGES)
                        $display("%0t: unexpected result, expected none, actual kind %0d",
                                 $time, m_tuser);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    compare_field("kind", want.kind, m_tuser);
                    compare_field("echo_char", want.echo, m_tdata[7:0]);
                    compare_field("position", want.pos, m_tdata[23:8]);
                    compare_field("error_code", want.err, m_tdata[26:24]);
                    compare_field("padding", 0, m_tdata[31:27]);
                end
            end

            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (recv_stall != 0)
            begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                recv_stall <= $urandom_range(1, 19) - 1;
                m_tready   <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        int pick;
        ctx_count  = 0;
        line_pos   = '0;
        line_error = ndl_pkg::ERR_NONE;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines. An array with digits, a comma and a dash, closed
        // cleanly.
        send_char(ndl_pkg::CH_LBRACKET);
        send_char(ndl_pkg::CH_ZERO + 8'd1);
        send_char(ndl_pkg::CH_COMMA);
        send_char(ndl_pkg::CH_DASH);
        send_char(ndl_pkg::CH_NINE);
        send_char(ndl_pkg::CH_RBRACKET);
        send_eol();
        // A quoted string inside braces; the NUL character, a space and the
        // other quote are all plain text in there.
        send_char(ndl_pkg::CH_LBRACE);
        send_char(ndl_pkg::CH_SQUOTE);
        send_char(8'h00);
        send_char(ndl_pkg::CH_SPACE);
        send_char(ndl_pkg::CH_DQUOTE);
        send_char(ndl_pkg::CH_SQUOTE);
        send_char(ndl_pkg::CH_RBRACE);
        send_eol();
        // Unterminated quote within a paren; the closer is quoted text.
        send_char(ndl_pkg::CH_LPAREN);
        send_char(ndl_pkg::CH_DQUOTE);
        send_char(ndl_pkg::CH_RPAREN);
        send_eol();
        // A space with a brace on top, then a sticky error to the line end.
        send_char(ndl_pkg::CH_LBRACE);
        send_char(ndl_pkg::CH_SPACE);
        send_char(8'hFF);
        send_eol();
        // Stray closers.
        send_char(ndl_pkg::CH_RPAREN);
        send_eol();
        send_char(ndl_pkg::CH_RBRACKET);
        send_eol();

        // The sender pauses until every directed token has been checked.
        wait_quiet();

        // The first half of the random traffic; the long receiver hold lands here.
        queued_items = 0;
        while (queued_items < RANDOM_ITEMS / 2)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                gen_nested_line($urandom_range(1, 40));
            else if (pick < 75)
                gen_deep_line();
            else
                gen_noise_line();
        end
        wait_quiet();

        queued_items = 0;
        while (queued_items < RANDOM_ITEMS / 2)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                gen_nested_line($urandom_range(1, 40));
            else if (pick < 75)
                gen_deep_line();
            else
                gen_noise_line();
        end

        // The closing stretch runs at full rate on both sides.
        while (pending_chars.size() != 0)
            @(negedge clk);
        idle_enable = 1'b0;
        queued_items = 0;
        while (queued_items < CLOSING_ITEMS)
            gen_nested_line($urandom_range(1, 40));

        while (pending_chars.size() != 0 || s_tvalid)
            @(negedge clk);
        for (i = 0; i < DRAIN_LIMIT && expected_tokens.size() != 0; i++)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (expected_tokens.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d tokens still expected, actual none", $time,
                     expected_tokens.size());
        end

        $display("Checked %0d results over %0d lines; deepest stack %0d.",
                 results_seen, lines_closed, deepest);
        $display("Kinds seen mask %05h, error codes seen mask %02h.",
                 kinds_seen, errors_seen);
        if (mismatches == 0)
            $display("nested_delimiter_lexer_core test passed");
        else
            $display("nested_delimiter_lexer_core test failed");
        $finish;
    end

    // Watchdog: a stuck handshake must not leave the run hanging.
    initial
    begin
        #10_000_000;
        $display("nested_delimiter_lexer_core test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/ndl_pkg.sv
rtl/ndl_classify.sv
rtl/ndl_stack.sv
rtl/nested_delimiter_lexer_core.sv
bench/nested_delimiter_lexer_core_test.sv
